// ===== sv/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared widths, register indexes, state and command codes of the PID
// controller with filtered derivative and PWM output.
// ----------------------------------------------------------------------------
`default_nettype none

package pfd_pkg;

	// field widths
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned ERR_W      = SAMPLE_W + 1;
	localparam int unsigned GAIN_W     = 24;
	localparam int unsigned ALPHA_W    = 17;
	localparam int unsigned LIM_W      = 16;
	localparam int unsigned DIR_W      = 2;
	localparam int unsigned DUTY_W     = 16;
	localparam int unsigned DRIVE_W    = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;

	// fixed point
	localparam int unsigned FRAC_BITS  = 16;
	localparam int unsigned ALPHA_FRAC = 16;
	localparam int unsigned PWM_MIN    = 0;

	// datapath widths
	localparam int unsigned ACC_W      = 48;
	localparam int unsigned MUL_W      = GAIN_W + 1;
	localparam int unsigned PROD_W     = 2 * MUL_W;
	localparam int unsigned DIFF_LO_W  = 22;
	localparam int unsigned DIFF_HI_W  = 21;
	localparam int unsigned DIFF_W     = DIFF_LO_W + DIFF_HI_W;
	localparam int unsigned FILT_W     = 64;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << ALPHA_FRAC);

	// register reset values
	localparam logic [GAIN_W-1:0]         GAIN_RST   = '0;
	localparam logic signed [LIM_W-1:0]   LIM_HI_RST = 16'sh7FFF;
	localparam logic signed [LIM_W-1:0]   LIM_LO_RST = -16'sh8000;

	// direction codes
	localparam logic [DIR_W-1:0] DIR_MINUS_ONE = 2'b11;
	localparam logic [DIR_W-1:0] DIR_ZERO      = 2'b00;
	localparam logic [DIR_W-1:0] DIR_PLUS_ONE  = 2'b01;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP_GAIN       = 3'd0,
		REG_KI_DT_GAIN    = 3'd1,
		REG_KD_DT_GAIN    = 3'd2,
		REG_FILTER_ALPHA  = 3'd3,
		REG_INTEGRAL_HIGH = 3'd4,
		REG_INTEGRAL_LOW  = 3'd5,
		REG_DRIVE_HIGH    = 3'd6,
		REG_DRIVE_LOW     = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_P,
		S_MUL_I,
		S_MUL_D,
		S_DIFF,
		S_MUL_LO,
		S_MUL_HI,
		S_FILT,
		S_SUM,
		S_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_P,
		OP_MUL_I,
		OP_MUL_D,
		OP_DIFF,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_FILT,
		OP_SUM,
		OP_OUT
	} dp_op_t;

endpackage

`default_nettype wire

// ===== sv/pfd_in_if.sv =====
// ----------------------------------------------------------------------------
// pfd_in_if
// Sample channel: one beat carries a target and a measured value.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfd_in_if;
	import pfd_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] target;
	logic signed [SAMPLE_W-1:0] measured;

	modport source (output valid, output target, output measured, input ready);
	modport sink (input valid, input target, input measured, output ready);
endinterface

`default_nettype wire

// ===== sv/pfd_out_if.sv =====
// ----------------------------------------------------------------------------
// pfd_out_if
// Result channel: one beat carries direction, pwm duty and clamped drive.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfd_out_if;
	import pfd_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [DIR_W-1:0]   direction;
	logic [DUTY_W-1:0]         pwm_duty;
	logic signed [DRIVE_W-1:0] drive;

	modport source (output valid, output direction, output pwm_duty, output drive, input ready);
	modport sink (input valid, input direction, input pwm_duty, input drive, output ready);
endinterface

`default_nettype wire

// ===== sv/pfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfd_ctrl
// Sequencer: steps the datapath through one sample and owns the result
// valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output pfd_pkg::dp_op_t       op
);
	import pfd_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		op        = OP_NONE;
		in_ready  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op        = OP_LOAD;
					state_nxt = S_MUL_P;
				end
			end
			S_MUL_P: begin
				op        = OP_MUL_P;
				state_nxt = S_MUL_I;
			end
			S_MUL_I: begin
				op        = OP_MUL_I;
				state_nxt = S_MUL_D;
			end
			S_MUL_D: begin
				op        = OP_MUL_D;
				state_nxt = S_DIFF;
			end
			S_DIFF: begin
				op        = OP_DIFF;
				state_nxt = S_MUL_LO;
			end
			S_MUL_LO: begin
				op        = OP_MUL_LO;
				state_nxt = S_MUL_HI;
			end
			S_MUL_HI: begin
				op        = OP_MUL_HI;
				state_nxt = S_FILT;
			end
			S_FILT: begin
				op        = OP_FILT;
				state_nxt = S_SUM;
			end
			S_SUM: begin
				op        = OP_SUM;
				state_nxt = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					op        = OP_OUT;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// a sample taken in idle starts the multiply sequence
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_MUL_P))
		else $error("accepted sample did not start the sequence");

	// a new result appears only out of the output step
	a_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_OUT))
		else $error("result valid raised outside the output step");

	// a free output register always takes the finished result
	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> (state_q == S_IDLE && out_valid_q))
		else $error("finished result not loaded into a free output register");

endmodule

`default_nettype wire

// ===== sv/pfd_dp.sv =====
// ----------------------------------------------------------------------------
// pfd_dp
// Datapath: configuration registers, controller state, one shared 25x25
// multiplier, clamps, derivative filter and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_dp #(
	parameter int unsigned PWM_MIN = pfd_pkg::PWM_MIN
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [pfd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [pfd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  wire pfd_pkg::dp_op_t                     op,
	input  wire logic signed [pfd_pkg::SAMPLE_W-1:0] target,
	input  wire logic signed [pfd_pkg::SAMPLE_W-1:0] measured,
	output logic signed [pfd_pkg::DIR_W-1:0]         direction,
	output logic [pfd_pkg::DUTY_W-1:0]               pwm_duty,
	output logic signed [pfd_pkg::DRIVE_W-1:0]       drive
);
	import pfd_pkg::*;

	localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'((1 << FRAC_BITS) - 1);

	// configuration
	logic [GAIN_W-1:0]        kp_q, ki_q, kd_q;
	logic [ALPHA_W-1:0]       alpha_q;
	logic signed [LIM_W-1:0]  ihi_q, ilo_q, dhi_q, dlo_q;

	// controller state
	logic signed [ERR_W-1:0]  prev_q;
	logic signed [ACC_W-1:0]  iacc_q;
	logic signed [ACC_W-1:0]  fd_q;

	// per-sample work registers
	logic signed [ERR_W-1:0]  e_q;
	logic signed [ACC_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]  up_q;
	logic signed [ACC_W-1:0]  lo_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [ACC_W-1:0]  u_q;

	// output register
	logic [DIR_W-1:0]         dir_q;
	logic [DUTY_W-1:0]        duty_q;
	logic [DRIVE_W-1:0]       drive_q;

	logic [ALPHA_W-1:0]       alpha_eff;
	logic signed [ERR_W:0]    de;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [ERR_W-1:0]  e_new;
	logic signed [ACC_W-1:0]  iacc_nxt;
	logic signed [ACC_W-1:0]  diff_full;
	logic signed [FILT_W-1:0] filt_hi, filt_lo, filt_sum, filt_sh;
	logic signed [ACC_W-1:0]  sum_full, u_nxt;
	logic signed [ACC_W-1:0]  u_bias, drv_full;
	logic signed [DRIVE_W:0]  drv_ext;
	logic [DRIVE_W:0]         mag;
	logic [DRIVE_W:0]         mag_adj;
	logic [DIR_W-1:0]         dir_nxt;

	function automatic logic signed [ACC_W-1:0] clamp_lim(
		input logic signed [ACC_W-1:0] v,
		input logic signed [LIM_W-1:0] hi,
		input logic signed [LIM_W-1:0] lo
	);
		logic signed [ACC_W-1:0] h;
		logic signed [ACC_W-1:0] l;
		h = {{(ACC_W-LIM_W){hi[LIM_W-1]}}, hi} <<< FRAC_BITS;
		l = {{(ACC_W-LIM_W){lo[LIM_W-1]}}, lo} <<< FRAC_BITS;
		if (v > h) begin
			return h;
		end else if (v < l) begin
			return l;
		end
		return v;
	endfunction

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= GAIN_RST;
			ki_q    <= GAIN_RST;
			kd_q    <= GAIN_RST;
			alpha_q <= ALPHA_ONE;
			ihi_q   <= LIM_HI_RST;
			ilo_q   <= LIM_LO_RST;
			dhi_q   <= LIM_HI_RST;
			dlo_q   <= LIM_LO_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_KP_GAIN:       kp_q    <= cfg_wdata[GAIN_W-1:0];
				REG_KI_DT_GAIN:    ki_q    <= cfg_wdata[GAIN_W-1:0];
				REG_KD_DT_GAIN:    kd_q    <= cfg_wdata[GAIN_W-1:0];
				REG_FILTER_ALPHA:  alpha_q <= cfg_wdata[ALPHA_W-1:0];
				REG_INTEGRAL_HIGH: ihi_q   <= cfg_wdata[LIM_W-1:0];
				REG_INTEGRAL_LOW:  ilo_q   <= cfg_wdata[LIM_W-1:0];
				REG_DRIVE_HIGH:    dhi_q   <= cfg_wdata[LIM_W-1:0];
				REG_DRIVE_LOW:     dlo_q   <= cfg_wdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign de        = {e_q[ERR_W-1], e_q} - {prev_q[ERR_W-1], prev_q};
	assign e_new     = {target[SAMPLE_W-1], target} - {measured[SAMPLE_W-1], measured};

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op)
			OP_MUL_P: begin
				mul_a = {1'b0, kp_q};
				mul_b = {{(MUL_W-ERR_W){e_q[ERR_W-1]}}, e_q};
			end
			OP_MUL_I: begin
				mul_a = {1'b0, ki_q};
				mul_b = {{(MUL_W-ERR_W){e_q[ERR_W-1]}}, e_q};
			end
			OP_MUL_D: begin
				mul_a = {1'b0, kd_q};
				mul_b = {{(MUL_W-ERR_W-1){de[ERR_W]}}, de};
			end
			OP_MUL_LO: begin
				mul_a = {{(MUL_W-ALPHA_W){1'b0}}, alpha_eff};
				mul_b = {{(MUL_W-DIFF_LO_W){1'b0}}, diff_q[DIFF_LO_W-1:0]};
			end
			OP_MUL_HI: begin
				mul_a = {{(MUL_W-ALPHA_W){1'b0}}, alpha_eff};
				mul_b = {{(MUL_W-DIFF_HI_W){diff_q[DIFF_W-1]}},
					diff_q[DIFF_W-1:DIFF_LO_W]};
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// integral with anti-windup clamp
	assign iacc_nxt  = clamp_lim(iacc_q + prod_q, ihi_q, ilo_q);
	assign diff_full = prod_q - fd_q;

	// filter: fd + floor(alpha * (ud - fd) / 2^16), split product recombined
	assign filt_hi  = {{(FILT_W-ACC_W){prod_q[ACC_W-1]}}, prod_q};
	assign filt_lo  = {{(FILT_W-ACC_W){lo_q[ACC_W-1]}}, lo_q};
	assign filt_sum = (filt_hi <<< DIFF_LO_W) + filt_lo;
	assign filt_sh  = filt_sum >>> ALPHA_FRAC;

	assign sum_full = up_q + fd_q + iacc_q;
	assign u_nxt    = clamp_lim(sum_full, dhi_q, dlo_q);

	// output stage: truncate toward zero, magnitude, direction
	assign u_bias   = u_q + ((u_q < 0) ? TRUNC_BIAS : '0);
	assign drv_full = u_bias >>> FRAC_BITS;
	assign drv_ext  = {drv_full[DRIVE_W-1], drv_full[DRIVE_W-1:0]};
	assign mag      = (drv_ext < 0) ? (DRIVE_W+1)'(0) - drv_ext : drv_ext;
	assign mag_adj  = (mag < (DRIVE_W+1)'(PWM_MIN) && e_q != 0) ? (DRIVE_W+1)'(PWM_MIN) : mag;
	assign dir_nxt  = (u_q > 0) ? DIR_MINUS_ONE : ((u_q < 0) ? DIR_PLUS_ONE : DIR_ZERO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			iacc_q <= '0;
			fd_q   <= '0;
		end else begin
			if (op == OP_MUL_D) begin
				iacc_q <= iacc_nxt;
			end
			if (op == OP_FILT) begin
				fd_q   <= fd_q + filt_sh[ACC_W-1:0];
				prev_q <= e_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: e_q <= e_new;
			OP_MUL_P: prod_q <= mul_p[ACC_W-1:0];
			OP_MUL_I: begin
				prod_q <= mul_p[ACC_W-1:0];
				up_q   <= prod_q;
			end
			OP_MUL_D: prod_q <= mul_p[ACC_W-1:0];
			OP_DIFF: diff_q <= diff_full[DIFF_W-1:0];
			OP_MUL_LO: prod_q <= mul_p[ACC_W-1:0];
			OP_MUL_HI: begin
				prod_q <= mul_p[ACC_W-1:0];
				lo_q   <= prod_q;
			end
			OP_SUM: u_q <= u_nxt;
			OP_OUT: begin
				dir_q   <= dir_nxt;
				duty_q  <= mag_adj[DUTY_W-1:0];
				drive_q <= drv_full[DRIVE_W-1:0];
			end
			default: ;
		endcase
	end

	assign direction = dir_q;
	assign pwm_duty  = duty_q;
	assign drive     = drive_q;

endmodule

`default_nettype wire

// ===== sv/pid_filtered_derivative_pwm.sv =====
// ----------------------------------------------------------------------------
// pid_filtered_derivative_pwm
// PID controller with low-pass filtered derivative, integral anti-windup and
// a direction / pwm output stage.
//
// usage
// - in_ch takes one sample per beat: target and measured, signed 16 bit
// - out_ch gives one result beat per sample: direction, pwm_duty, drive
// - cfg_we / cfg_index / cfg_wdata write the gain, filter and limit
//   registers; write only while no sample is in flight
// - one sample takes the accept step plus nine sequencer steps
//   (three gain products, the filter difference, a split 17x43 filter
//   product on the one shared 25x25 multiplier, filter update, sum and
//   clamp, output load); result valid is registered by the output load
// - a new sample is accepted only once the sequencer is back in idle
// - the output register holds the last result, so the next sample is
//   accepted while that result still waits for the receiver
// - a stalled receiver parks the sequencer in its output step; in_ch
//   stays not ready until the previous result has left
// - reset clears the integral, filter and previous error, restores the
//   register defaults and drops result valid
// ----------------------------------------------------------------------------
`default_nettype none

module pid_filtered_derivative_pwm #(
	parameter int unsigned PWM_MIN = pfd_pkg::PWM_MIN
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [pfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	pfd_in_if.sink                              in_ch,
	pfd_out_if.source                           out_ch
);
	import pfd_pkg::*;

	// sequencer command to the datapath
	dp_op_t op;
	logic   in_ready;
	logic   out_valid;

	pfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.op        (op)
	);

	// arithmetic, state and output register
	pfd_dp #(
		.PWM_MIN (PWM_MIN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.op        (op),
		.target    (in_ch.target),
		.measured  (in_ch.measured),
		.direction (out_ch.direction),
		.pwm_duty  (out_ch.pwm_duty),
		.drive     (out_ch.drive)
	);

	// handshake wiring
	assign in_ch.ready  = in_ready;
	assign out_ch.valid = out_valid;

endmodule

`default_nettype wire

// ===== dv/pid_filtered_derivative_pwm_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_filtered_derivative_pwm_test
// Self-checking bench for the PID controller with filtered derivative. A
// queue-fed driver sends target / measured beats with random gaps, a monitor
// predicts every result from its own copy of the controller state and checks
// each result beat field by field, while the gains, the filter factor and the
// clamps are rewritten between phases whenever the block is idle.
// ----------------------------------------------------------------------------

module pid_filtered_derivative_pwm_test;
	import pfd_pkg::*;

	localparam longint ALPHA_UNITY = 65536;
	localparam int     RAND_PHASES = 12;
	localparam int     PHASE_ITEMS = 112;

	typedef struct {
		logic signed [SAMPLE_W-1:0] target;
		logic signed [SAMPLE_W-1:0] measured;
	} sample_t;

	typedef struct {
		logic signed [DIR_W-1:0]   direction;
		logic [DUTY_W-1:0]         pwm_duty;
		logic signed [DRIVE_W-1:0] drive;
	} pid_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	pfd_in_if  in_if ();
	pfd_out_if out_if ();

	pid_filtered_derivative_pwm i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_if),
		.out_ch   (out_if)
	);

	// stimulus waiting for the driver, and results the predictor has formed
	sample_t     pending_samples[$];
	pid_result_t expected_results[$];

	// predictor copy of the registers, integer parts kept sign-extended
	longint kp_q, ki_dt_q, kd_dt_q, alpha_q;
	longint int_hi_q, int_lo_q, drv_hi_q, drv_lo_q;
	// predictor copy of the controller state
	longint prev_err_q, integral_q, filt_deriv_q;

	int          mismatches   = 0;
	int          samples_sent = 0;
	int          results_seen = 0;
	int          reg_writes   = 0;
	bit          quiet        = 1'b0;
	bit          in_taken     = 1'b0;
	int          send_gap     = 0;
	int          recv_stall   = 0;
	pid_result_t want;

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	function automatic void reset_controller();
		kp_q         = 0;
		ki_dt_q      = 0;
		kd_dt_q      = 0;
		alpha_q      = ALPHA_UNITY;
		int_hi_q     = 32767;
		int_lo_q     = -32768;
		drv_hi_q     = 32767;
		drv_lo_q     = -32768;
		prev_err_q   = 0;
		integral_q   = 0;
		filt_deriv_q = 0;
	endfunction

	function automatic void load_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (cfg_idx_t'(idx))
			REG_KP_GAIN:       kp_q     = longint'(data[GAIN_W-1:0]);
			REG_KI_DT_GAIN:    ki_dt_q  = longint'(data[GAIN_W-1:0]);
			REG_KD_DT_GAIN:    kd_dt_q  = longint'(data[GAIN_W-1:0]);
			REG_FILTER_ALPHA:  alpha_q  = longint'(data[ALPHA_W-1:0]);
			REG_INTEGRAL_HIGH: int_hi_q = longint'($signed(data[LIM_W-1:0]));
			REG_INTEGRAL_LOW:  int_lo_q = longint'($signed(data[LIM_W-1:0]));
			REG_DRIVE_HIGH:    drv_hi_q = longint'($signed(data[LIM_W-1:0]));
			REG_DRIVE_LOW:     drv_lo_q = longint'($signed(data[LIM_W-1:0]));
			default: ;
		endcase
	endfunction

	// high limit is tested first; with inverted limits a value above it resolves to it, any other to the low one
	function automatic longint clamp_fixed(longint v, longint hi, longint lo);
		longint h, l;
		h = hi * (longint'(1) << FRAC_BITS);
		l = lo * (longint'(1) << FRAC_BITS);
		if (v > h)
			return h;
		if (v < l)
			return l;
		return v;
	endfunction

	function automatic pid_result_t pid_step(logic signed [SAMPLE_W-1:0] tgt,
		logic signed [SAMPLE_W-1:0] meas);
		longint      err, alpha, p_term, i_term, d_raw, d_filt, sum, drv, mag;
		pid_result_t r;
		err   = longint'(tgt) - longint'(meas);
		// alpha above one saturates to one
		alpha = (alpha_q > ALPHA_UNITY) ? ALPHA_UNITY : alpha_q;

		p_term = kp_q * err;
		i_term = clamp_fixed(integral_q + ki_dt_q * err, int_hi_q, int_lo_q);
		d_raw  = kd_dt_q * (err - prev_err_q);
		// filter output rounds toward minus infinity
		d_filt = ((ALPHA_UNITY - alpha) * filt_deriv_q + alpha * d_raw) >>> ALPHA_FRAC;

		prev_err_q   = err;
		integral_q   = i_term;
		filt_deriv_q = d_filt;

		sum = clamp_fixed(p_term + d_filt + i_term, drv_hi_q, drv_lo_q);
		if (sum > 0)
			r.direction = DIR_MINUS_ONE;
		else if (sum < 0)
			r.direction = DIR_PLUS_ONE;
		else
			r.direction = DIR_ZERO;
		// drive truncates toward zero
		drv = (sum >= 0) ? (sum >>> FRAC_BITS) : -((-sum) >>> FRAC_BITS);
		mag = (drv < 0) ? -drv : drv;
		if (mag < longint'(PWM_MIN) && err != 0)
			mag = longint'(PWM_MIN);
		r.pwm_duty = mag[DUTY_W-1:0];
		r.drive    = drv[DRIVE_W-1:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// random helpers
	// ------------------------------------------------------------------

	// idle lengths: mostly none or short, a few long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_gain();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3:    return CFG_DATA_W'($urandom);
			default: return CFG_DATA_W'($urandom_range(0, 1 << 17));
		endcase
	endfunction

	// alpha: unity, zero, inside the range, or above one
	function automatic logic [ALPHA_W-1:0] pick_alpha();
		case ($urandom_range(0, 5))
			0:       return ALPHA_ONE;
			1:       return '0;
			2:       return ALPHA_W'($urandom_range(65537, 131071));
			default: return ALPHA_W'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_extreme();
		case ($urandom_range(0, 3))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2:       return '0;
			default: return '1;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// configuration and stimulus tasks
	// ------------------------------------------------------------------

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// limit registers use only the low 16 bits, upper bits are random junk
	task automatic write_limit(cfg_idx_t idx, logic [LIM_W-1:0] value);
		write_reg(idx, {8'($urandom), value});
	endtask

	task automatic pick_limits(cfg_idx_t hi_idx, cfg_idx_t lo_idx);
		logic signed [LIM_W-1:0] a, b;
		a = LIM_W'($urandom);
		b = LIM_W'($urandom);
		case ($urandom_range(0, 5))
			0: begin
				a = LIM_HI_RST;
				b = LIM_LO_RST;
			end
			1: begin
				// inverted pair
				if (a > b) begin
					a = a ^ b;
					b = a ^ b;
					a = a ^ b;
				end
			end
			2: b = a;
			default: begin
				if (a < b) begin
					a = a ^ b;
					b = a ^ b;
					a = a ^ b;
				end
			end
		endcase
		write_limit(hi_idx, a);
		write_limit(lo_idx, b);
	endtask

	task automatic randomize_config();
		write_reg(REG_KP_GAIN, pick_gain());
		write_reg(REG_KI_DT_GAIN, pick_gain());
		write_reg(REG_KD_DT_GAIN, pick_gain());
		write_reg(REG_FILTER_ALPHA, {7'($urandom), pick_alpha()});
		pick_limits(REG_INTEGRAL_HIGH, REG_INTEGRAL_LOW);
		pick_limits(REG_DRIVE_HIGH, REG_DRIVE_LOW);
	endtask

	task automatic queue_sample(logic signed [SAMPLE_W-1:0] tgt, logic signed [SAMPLE_W-1:0] meas);
		sample_t s;
		s.target   = tgt;
		s.measured = meas;
		pending_samples.push_back(s);
	endtask

	// mixture of full-range noise, a slowly moving setpoint tracked closely
	// (keeps the integral and the filter out of saturation), and extremes
	task automatic queue_random_phase(int count);
		logic signed [SAMPLE_W-1:0] walk;
		int                         step;
		int                         roll;
		walk = SAMPLE_W'($urandom);
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 9);
			if (roll < 3) begin
				queue_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
			end else if (roll < 9) begin
				step = $urandom_range(0, 64);
				walk = walk + SAMPLE_W'(step - 32);
				step = $urandom_range(0, 16);
				queue_sample(walk, walk + SAMPLE_W'(step - 8));
			end else begin
				queue_sample(pick_extreme(), pick_extreme());
			end
		end
	endtask

	// every sample gives one result, so the block is idle once both queues drain
	task automatic drain();
		while (pending_samples.size() != 0 || expected_results.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// sample driver: changes inputs at the falling edge
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		bit hold;
		if (arst_n) begin
			hold = in_if.valid;
			// beat went out at the last rising edge
			if (hold && in_taken) begin
				void'(pending_samples.pop_front());
				samples_sent++;
				hold     = 1'b0;
				send_gap = pick_gap();
			end
			if (!hold) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_samples.size() != 0) begin
					hold = 1'b1;
					in_if.target   <= pending_samples[0].target;
					in_if.measured <= pending_samples[0].measured;
				end
			end
			in_if.valid <= hold;

			// receiver back-pressure
			if (recv_stall > 0) begin
				recv_stall--;
				out_if.ready <= 1'b0;
			end else begin
				out_if.ready <= 1'b1;
				recv_stall = pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: samples at the rising edge, predicts and checks
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (!arst_n) begin
			reset_controller();
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_if.valid && in_if.ready;
			if (cfg_we) begin
				load_register(cfg_index, cfg_wdata);
				reg_writes++;
			end
			// accepted sample beat: form the expected result
			if (in_if.valid && in_if.ready)
				expected_results.push_back(pid_step(in_if.target, in_if.measured));
			// accepted result beat: compare with the oldest expectation
			if (out_if.valid && out_if.ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with nothing expected: dir %0d duty %0d drive %0d",
						$time, out_if.direction, out_if.pwm_duty, out_if.drive);
				end else begin
					want = expected_results.pop_front();
					if (out_if.direction !== want.direction) begin
						mismatches++;
						$display("%0t: direction expected %0d actual %0d",
							$time, want.direction, out_if.direction);
					end
					if (out_if.pwm_duty !== want.pwm_duty) begin
						mismatches++;
						$display("%0t: pwm_duty expected %0d actual %0d",
							$time, want.pwm_duty, out_if.pwm_duty);
					end
					if (out_if.drive !== want.drive) begin
						mismatches++;
						$display("%0t: drive expected %0d actual %0d",
							$time, want.drive, out_if.drive);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_wdata       = '0;
		in_if.valid     = 1'b0;
		in_if.target    = '0;
		in_if.measured  = '0;
		out_if.ready    = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// register defaults: all gains zero, so everything reads zero
		queue_sample(16'sh7FFF, 16'sh8000);
		queue_sample(16'sh8000, 16'sh7FFF);
		drain();

		// unity proportional gain only: field extremes, full negative drive,
		// zero drive and small errors of both signs
		write_reg(REG_KP_GAIN, 24'h010000);
		queue_sample(16'sh7FFF, 16'sh8000);
		queue_sample(16'sh8000, 16'sh7FFF);
		queue_sample(16'sh0000, 16'sh0000);
		queue_sample(16'sh0005, 16'sh0003);
		queue_sample(16'sh0003, 16'sh0005);
		queue_sample(16'sh7FFF, 16'sh7FFF);
		drain();

		// full-scale gains, heavy filtering and inverted limits on both clamps
		write_reg(REG_KP_GAIN, 24'hFFFFFF);
		write_reg(REG_KI_DT_GAIN, 24'hFFFFFF);
		write_reg(REG_KD_DT_GAIN, 24'hFFFFFF);
		write_reg(REG_FILTER_ALPHA, 24'h000000);
		write_limit(REG_INTEGRAL_HIGH, 16'hFF9C);
		write_limit(REG_INTEGRAL_LOW, 16'h0064);
		write_limit(REG_DRIVE_HIGH, 16'h8000);
		write_limit(REG_DRIVE_LOW, 16'h7FFF);
		queue_sample(16'sh7FFF, 16'sh8000);
		queue_sample(16'sh8000, 16'sh7FFF);
		queue_sample(16'sh0000, 16'sh0001);
		queue_sample(16'sh0001, 16'sh0000);
		drain();

		// alpha above one saturates; small derivative gain exercises filter
		// rounding of negative values
		write_reg(REG_KP_GAIN, 24'h000000);
		write_reg(REG_KI_DT_GAIN, 24'h000100);
		write_reg(REG_KD_DT_GAIN, 24'h000003);
		write_reg(REG_FILTER_ALPHA, 24'hFFFFFF);
		write_limit(REG_INTEGRAL_HIGH, 16'h7FFF);
		write_limit(REG_INTEGRAL_LOW, 16'h8000);
		write_limit(REG_DRIVE_HIGH, 16'h7FFF);
		write_limit(REG_DRIVE_LOW, 16'h8000);
		queue_sample(16'sh0010, 16'sh0000);
		queue_sample(16'sh0000, 16'sh0010);
		queue_sample(16'shFFF0, 16'sh0000);
		drain();
		write_reg(REG_FILTER_ALPHA, 24'h000001);
		queue_sample(16'sh0000, 16'sh0123);
		queue_sample(16'sh0123, 16'sh0000);
		queue_sample(16'sh0000, 16'sh0000);
		drain();

		// random phases, every fourth one without idling on either side
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			quiet = (ph % 4 == 3);
			randomize_config();
			queue_random_phase(PHASE_ITEMS);
			drain();
		end

		// let any stray result show up before closing
		repeat (20) @(negedge clk);
		$display("run covered %0d samples and %0d results over %0d register writes",
			samples_sent, results_seen, reg_writes);
		$display("phases: defaults, unit gain, full-scale gains with inverted limits, %0d random",
			RAND_PHASES);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			if (expected_results.size() != 0)
				$display("%0t: %0d expected results never arrived", $time, expected_results.size());
			$display("Mismatches found");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20000000;
		$display("%0t: timeout with %0d samples pending and %0d results outstanding",
			$time, pending_samples.size(), expected_results.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
